### rtl/mcdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcdd_pkg: shared types and codes for the max-cut DD node update
// Command, side and mode codes, the input item and node state structs.
// ----------------------------------------------------------------------------
package mcdd_pkg;

	localparam logic [1:0] CMD_TR_START = 2'd0;
	localparam logic [1:0] CMD_TR_ELEM  = 2'd1;
	localparam logic [1:0] CMD_MG_START = 2'd2;
	localparam logic [1:0] CMD_MG_ELEM  = 2'd3;

	localparam logic [1:0] SIDE_S = 2'd0;
	localparam logic [1:0] SIDE_T = 2'd1;

	localparam logic [1:0] MODE_S       = 2'd0;
	localparam logic [1:0] MODE_T       = 2'd1;
	localparam logic [1:0] MODE_RELAXED = 2'd2;
	localparam logic [1:0] MODE_MERGE   = 2'd3;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [1:0]          side;
		logic signed [15:0]  weight_a;
		logic signed [15:0]  weight_b;
		logic signed [31:0]  value_a;
		logic signed [31:0]  value_b;
		logic                last;
	} item_t;

	typedef struct packed {
		logic [1:0]          op_mode;
		logic signed [31:0]  acc_first;
		logic signed [31:0]  acc_second;
		logic signed [31:0]  base_bound;
	} state_t;

endpackage

### rtl/mcdd_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcdd_item_if: input item channel
// Valid/ready channel carrying one command item per beat.
// ----------------------------------------------------------------------------
interface mcdd_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [1:0]         side;
	logic signed [15:0] weight_a;
	logic signed [15:0] weight_b;
	logic signed [31:0] value_a;
	logic signed [31:0] value_b;
	logic               last;

	modport source (output valid, cmd, side, weight_a, weight_b, value_a, value_b, last,
		input ready);
	modport sink (input valid, cmd, side, weight_a, weight_b, value_a, value_b, last,
		output ready);
endinterface

### rtl/mcdd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcdd_result_if: result channel
// Valid/ready channel carrying one residual weight and/or final bound per beat.
// ----------------------------------------------------------------------------
interface mcdd_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] new_weight;
	logic               weight_valid;
	logic signed [31:0] bound_value;
	logic               is_final;

	modport source (output valid, new_weight, weight_valid, bound_value, is_final,
		input ready);
	modport sink (input valid, new_weight, weight_valid, bound_value, is_final,
		output ready);
endinterface

### rtl/mcdd_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcdd_update: per-item node state update
// Combinational next-state and residual weight for one item: S/T/relaxed
// transition elements, merge elements and the two start commands.
// ----------------------------------------------------------------------------
module mcdd_update (
	input  mcdd_pkg::item_t     item,
	input  mcdd_pkg::state_t    cur,
	output mcdd_pkg::state_t    nxt,
	output logic signed [15:0]  new_weight,
	output logic                elem
);
	import mcdd_pkg::*;

	function automatic logic signed [16:0] relax17(input logic signed [16:0] x,
		input logic signed [16:0] y);
		if (!x[16] && !y[16])
			relax17 = (x < y) ? x : y;
		else if (x <= 17'sd0 && y <= 17'sd0)
			relax17 = (x > y) ? x : y;
		else
			relax17 = '0;
	endfunction

	function automatic logic [16:0] abs17(input logic signed [16:0] x);
		abs17 = x[16] ? 17'(-x) : 17'(x);
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
		input logic [17:0] add);
		logic signed [33:0] s;
		s = $signed({{2{acc[31]}}, acc}) + $signed({16'b0, add});
		// add is never negative: only the top can overflow
		if (!s[33] && s[32:31] != 2'b00)
			sat_add = 32'sh7FFF_FFFF;
		else
			sat_add = s[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
		if (x[16] != x[15])
			sat16 = x[16] ? 16'sh8000 : 16'sh7FFF;
		else
			sat16 = x[15:0];
	endfunction

	logic signed [16:0] wa17, wb17, ws, wt, r_t, r_m, nw17;
	logic [16:0]        abs_a, abs_b, abs_ws, abs_wt, abs_rt, abs_rm, m;
	logic               zero_pd, prod_le, prod_ge;
	logic [17:0]        add_f, add_s;
	logic [31:0]        pos_a, neg_a;

	always_comb begin
		wa17    = {item.weight_a[15], item.weight_a};
		wb17    = {item.weight_b[15], item.weight_b};
		ws      = wa17 + wb17;
		wt      = wa17 - wb17;
		abs_a   = abs17(wa17);
		abs_b   = abs17(wb17);
		m       = (abs_a < abs_b) ? abs_a : abs_b;
		r_t     = relax17(ws, wt);
		r_m     = relax17(wa17, wb17);
		abs_ws  = abs17(ws);
		abs_wt  = abs17(wt);
		abs_rt  = abs17(r_t);
		abs_rm  = abs17(r_m);
		// sign of the product without a multiplier
		zero_pd = (item.weight_a == 16'sd0) || (item.weight_b == 16'sd0);
		prod_le = zero_pd || (item.weight_a[15] != item.weight_b[15]);
		prod_ge = zero_pd || (item.weight_a[15] == item.weight_b[15]);
		pos_a   = item.weight_a[15] ? 32'd0 : {16'd0, item.weight_a};
		neg_a   = item.weight_a[15] ? {15'd0, abs_a} : 32'd0;

		nxt   = cur;
		nw17  = '0;
		elem  = 1'b0;
		add_f = '0;
		add_s = '0;

		unique case (item.cmd)
			CMD_TR_START: begin
				nxt.op_mode    = (item.side == SIDE_S || item.side == SIDE_T) ?
					item.side : MODE_RELAXED;
				nxt.base_bound = item.value_a;
				nxt.acc_first  = (item.side == SIDE_T) ? pos_a : neg_a;
				nxt.acc_second = pos_a;
			end
			CMD_MG_START: begin
				nxt.op_mode    = MODE_MERGE;
				nxt.base_bound = '0;
				nxt.acc_first  = item.value_a;
				nxt.acc_second = item.value_b;
			end
			CMD_TR_ELEM: begin
				elem = 1'b1;
				case (cur.op_mode)
					MODE_S: begin
						nw17 = ws;
						if (prod_le)
							add_f = {1'b0, m};
					end
					MODE_T: begin
						nw17 = wt;
						if (prod_ge)
							add_f = {1'b0, m};
					end
					default: begin
						// relaxed: a merge mode counts as relaxed here too
						nw17  = r_t;
						add_f = (prod_le ? {1'b0, m} : 18'd0) + {1'b0, abs_ws}
							- {1'b0, abs_rt};
						add_s = (prod_le ? 18'd0 : {1'b0, m}) + {1'b0, abs_wt}
							- {1'b0, abs_rt};
					end
				endcase
			end
			CMD_MG_ELEM: begin
				elem  = 1'b1;
				nw17  = r_m;
				add_f = {1'b0, abs_a} - {1'b0, abs_rm};
				add_s = {1'b0, abs_b} - {1'b0, abs_rm};
			end
			default: ;
		endcase

		if (elem) begin
			nxt.acc_first  = sat_add(cur.acc_first, add_f);
			nxt.acc_second = sat_add(cur.acc_second, add_s);
		end
		new_weight = sat16(nw17);
	end

endmodule

### rtl/max_cut_dd_node_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_cut_dd_node_update: streamed max-cut decision-diagram node update
// Input register, state/accumulator stage, final-bound output register.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall. A beat
// lands in the input register when accepted, passes the accumulation stage
// and then reaches the output register, which drives its result beat.
// The node state (mode, both accumulators, base bound) is updated as an item
// leaves the input register, so consecutive elements chain through the
// accumulators with no bubble; the saturated final add of base and the
// chosen accumulator is done in the last stage. A start item without last
// returns nothing; every element, and any item marked last, returns one
// beat. Backpressure on the result side fills the three stages before
// ready drops on the input side.
module max_cut_dd_node_update (
	input logic                 clk,
	input logic                 arst_n,
	mcdd_item_if.sink           items,
	mcdd_result_if.source       results
);
	import mcdd_pkg::*;

	item_t              item_s1;
	logic               v_s1;
	state_t             state_q, state_nxt;
	logic signed [15:0] nw_upd, nw_s2;
	logic               elem_upd, elem_s2, last_s2, v_s2;
	logic [1:0]         mode_s2;
	logic signed [31:0] f_s2, s_s2, base_s2;
	logic signed [15:0] nw_s3;
	logic               elem_s3, last_s3, v_s3;
	logic signed [31:0] bound_s3;
	logic               q_free, s2_free, adv1, adv2;
	logic signed [31:0] sel;
	logic signed [32:0] fsum;
	logic signed [31:0] fbound;

	mcdd_update u_update (
		.item       (item_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.new_weight (nw_upd),
		.elem       (elem_upd)
	);

	assign q_free      = !v_s3 || results.ready;
	assign s2_free     = !v_s2 || q_free;
	assign adv1        = v_s1 && s2_free;
	assign adv2        = v_s2 && q_free;
	assign items.ready = !v_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			state_q <= '0;
		end else begin
			if (items.ready)
				v_s1 <= items.valid;
			if (s2_free)
				v_s2 <= v_s1;
			// drop beats that carry no result
			if (q_free)
				v_s3 <= v_s2 && (elem_s2 || last_s2);
			if (adv1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.cmd      <= items.cmd;
			item_s1.side     <= items.side;
			item_s1.weight_a <= items.weight_a;
			item_s1.weight_b <= items.weight_b;
			item_s1.value_a  <= items.value_a;
			item_s1.value_b  <= items.value_b;
			item_s1.last     <= items.last;
		end
		if (adv1) begin
			nw_s2   <= nw_upd;
			elem_s2 <= elem_upd;
			last_s2 <= item_s1.last;
			mode_s2 <= state_nxt.op_mode;
			f_s2    <= state_nxt.acc_first;
			s_s2    <= state_nxt.acc_second;
			base_s2 <= state_nxt.base_bound;
		end
		if (adv2) begin
			nw_s3    <= elem_s2 ? nw_s2 : 16'sd0;
			elem_s3  <= elem_s2;
			last_s3  <= last_s2;
			bound_s3 <= last_s2 ? fbound : 32'sd0;
		end
	end

	// final bound: relaxed and merge take the larger accumulator
	always_comb begin
		if (mode_s2 == MODE_RELAXED || mode_s2 == MODE_MERGE)
			sel = (f_s2 > s_s2) ? f_s2 : s_s2;
		else
			sel = f_s2;
		fsum = {base_s2[31], base_s2} + {sel[31], sel};
		if (fsum[32] != fsum[31])
			fbound = fsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			fbound = fsum[31:0];
	end

	assign results.valid        = v_s3;
	assign results.new_weight   = nw_s3;
	assign results.weight_valid = elem_s3;
	assign results.bound_value  = bound_s3;
	assign results.is_final     = last_s3;

	a_merge_start: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && item_s1.cmd == CMD_MG_START) |=>
			(state_q.op_mode == MODE_MERGE && state_q.base_bound == 32'sd0))
		else $error("merge start did not set merge mode");

	a_no_result_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && !elem_s2 && !last_s2) |=> !v_s3)
		else $error("start item without last produced a result beat");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> (v_s1 && v_s2 && v_s3 && !results.ready))
		else $error("input stalled while a stage was free");

endmodule
